// ----- src/iss_pkg.sv -----
// Shared types and command codes for the identifier selection set.
package iss_pkg;

  localparam int unsigned IdentW = 32;
  localparam int unsigned CmdW   = 2;

  // Command codes; code 3 behaves as a query.
  localparam logic [CmdW-1:0] CMD_UPDATE = 2'd0;
  localparam logic [CmdW-1:0] CMD_QUERY  = 2'd1;
  localparam logic [CmdW-1:0] CMD_CLEAR  = 2'd2;

  typedef struct packed {
    logic [CmdW-1:0]          cmd;
    logic signed [IdentW-1:0] ident;
    logic                     want_member;
  } iss_req_t;

  typedef struct packed {
    logic was_member;
    logic table_full;
  } iss_rsp_t;

endpackage

// ----- src/id_selection_set_core.sv -----
// Identifier selection set: slot table scanned by a small microcoded sequencer.
// Sequence: a request is accepted in IDLE, then SCAN reads one slot per cycle
//   over CAPACITY slots, DRAIN compares the last slot read and COMMIT writes
//   the table and loads the result, waiting while a stalled result is held.
// Requests: a new one is taken only after COMMIT; a finished result waits in
//   the output register while the next request is taken.
// Reset: async, active low. After reset a clearing pass zeroes every
//   slot; in_stall_o stays high during that pass.
module id_selection_set_core
  import iss_pkg::*;
#(
  parameter int unsigned CAPACITY = 64
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  iss_req_t in_req_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output iss_rsp_t out_rsp_o
);

  // Slot index width; at least one bit so a single-slot table still works.
  localparam int unsigned IdxW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam logic [IdxW-1:0] IdxLast = IdxW'(CAPACITY - 1);

  // Microprogram steps.
  typedef enum logic [2:0] {
    STEP_INIT,    // clearing pass after reset
    STEP_IDLE,    // wait for a request
    STEP_SCAN,    // read one slot per cycle
    STEP_DRAIN,   // compare the last slot read
    STEP_COMMIT   // write the table, hand the result to the output register
  } step_e;

  // Jump conditions.
  typedef enum logic [1:0] {
    COND_ALWAYS,
    COND_IN,
    COND_LAST,
    COND_OUT_FREE
  } cond_e;

  // One control word per step.
  typedef struct packed {
    logic  accept;     // take a request this cycle
    logic  rd;         // read slot at the scan index
    logic  idx_inc;    // advance the scan index
    logic  idx_clr;    // restart the scan index and hit/empty flags
    logic  zero_all;   // write zero at the scan index unconditionally
    logic  zero_clr;   // write zero at the scan index on a clear command
    logic  commit;     // final table write and result load
    cond_e cond;
    step_e tgt_t;
    step_e tgt_f;
  } ctl_t;

  // Microcode ROM.
  function automatic ctl_t ucode(step_e s);
    ctl_t c;
    c = '{accept: 1'b0, rd: 1'b0, idx_inc: 1'b0, idx_clr: 1'b0, zero_all: 1'b0,
          zero_clr: 1'b0, commit: 1'b0, cond: COND_ALWAYS,
          tgt_t: STEP_IDLE, tgt_f: STEP_IDLE};
    case (s)
      STEP_INIT: begin
        c.zero_all = 1'b1;
        c.idx_inc  = 1'b1;
        c.cond     = COND_LAST;
        c.tgt_t    = STEP_IDLE;
        c.tgt_f    = STEP_INIT;
      end
      STEP_IDLE: begin
        c.accept  = 1'b1;
        c.idx_clr = 1'b1;
        c.cond    = COND_IN;
        c.tgt_t   = STEP_SCAN;
        c.tgt_f   = STEP_IDLE;
      end
      STEP_SCAN: begin
        c.rd       = 1'b1;
        c.idx_inc  = 1'b1;
        c.zero_clr = 1'b1;
        c.cond     = COND_LAST;
        c.tgt_t    = STEP_DRAIN;
        c.tgt_f    = STEP_SCAN;
      end
      STEP_DRAIN: begin
        c.cond  = COND_ALWAYS;
        c.tgt_t = STEP_COMMIT;
        c.tgt_f = STEP_COMMIT;
      end
      STEP_COMMIT: begin
        c.commit = 1'b1;
        c.cond   = COND_OUT_FREE;
        c.tgt_t  = STEP_IDLE;
        c.tgt_f  = STEP_COMMIT;
      end
      default: begin
        c.tgt_t = STEP_INIT;
        c.tgt_f = STEP_INIT;
      end
    endcase
    return c;
  endfunction

  // Sequencer and datapath registers.
  step_e            upc_q, upc_d;
  logic [IdxW-1:0]  idx_q, idx_d;
  iss_req_t         req_q, req_d;
  logic             pos_q, pos_d;        // identifier is positive
  logic             cmp_v_q, cmp_v_d;    // slot data valid for compare
  logic [IdxW-1:0]  cmp_idx_q, cmp_idx_d;
  logic             hit_q, hit_d;
  logic [IdxW-1:0]  hit_idx_q, hit_idx_d;
  logic             empty_q, empty_d;    // an empty slot was found
  logic [IdxW-1:0]  empty_idx_q, empty_idx_d;
  logic             out_valid_q, out_valid_d;
  iss_rsp_t         out_q, out_d;

  // Slot memory.
  logic [IdentW-1:0] slot_mem [CAPACITY];
  logic [IdentW-1:0] rdata_q;
  logic              mem_we;
  logic [IdxW-1:0]   mem_wa;
  logic [IdentW-1:0] mem_wd;

  ctl_t ctl;
  logic cond_true;
  logic in_acc;
  logic out_free;
  logic is_update;
  logic do_insert;
  logic do_remove;
  logic do_drop;

  assign ctl      = ucode(upc_q);
  assign in_acc   = ctl.accept && in_valid_i;
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    case (ctl.cond)
      COND_ALWAYS:   cond_true = 1'b1;
      COND_IN:       cond_true = in_valid_i;
      COND_LAST:     cond_true = (idx_q == IdxLast);
      COND_OUT_FREE: cond_true = out_free;
      default:       cond_true = 1'b1;
    endcase
  end

  // Final decision, made from the scan flags in the commit step.
  assign is_update = (req_q.cmd == CMD_UPDATE) && pos_q;
  assign do_insert = is_update && !hit_q && req_q.want_member && empty_q;
  assign do_drop   = is_update && !hit_q && req_q.want_member && !empty_q;
  assign do_remove = is_update && hit_q && !req_q.want_member;

  // Memory write port: zero during clearing and during a clear command's scan, key or zero at commit.
  always_comb begin
    mem_we = 1'b0;
    mem_wa = idx_q;
    mem_wd = '0;
    if (ctl.zero_all || (ctl.zero_clr && req_q.cmd == CMD_CLEAR)) begin
      mem_we = 1'b1;
    end else if (ctl.commit && out_free) begin
      if (do_insert) begin
        mem_we = 1'b1;
        mem_wa = empty_idx_q;
        mem_wd = req_q.ident;
      end else if (do_remove) begin
        mem_we = 1'b1;
        mem_wa = hit_idx_q;
      end
    end
  end

  // Read is registered; a clear write at the same slot returns old data.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      slot_mem[mem_wa] <= mem_wd;
    end
    if (ctl.rd) begin
      rdata_q <= slot_mem[idx_q];
    end
  end

  always_comb begin
    upc_d       = cond_true ? ctl.tgt_t : ctl.tgt_f;
    idx_d       = idx_q;
    req_d       = req_q;
    pos_d       = pos_q;
    cmp_v_d     = ctl.rd;
    cmp_idx_d   = idx_q;
    hit_d       = hit_q;
    hit_idx_d   = hit_idx_q;
    empty_d     = empty_q;
    empty_idx_d = empty_idx_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;

    if (ctl.idx_inc) begin
      idx_d = (idx_q == IdxLast) ? '0 : idx_q + 1'b1;
    end
    if (ctl.idx_clr) begin
      idx_d   = '0;
      hit_d   = 1'b0;
      empty_d = 1'b0;
    end
    if (in_acc) begin
      req_d = in_req_i;
      pos_d = (in_req_i.ident > 0);
    end

    // Compare stage: match on the key, first empty slot in index order.
    if (cmp_v_q) begin
      if (pos_q && !hit_q && rdata_q == req_q.ident) begin
        hit_d     = 1'b1;
        hit_idx_d = cmp_idx_q;
      end
      if (!empty_q && rdata_q == '0) begin
        empty_d     = 1'b1;
        empty_idx_d = cmp_idx_q;
      end
    end

    // Output register.
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (ctl.commit && out_free) begin
      out_valid_d      = 1'b1;
      out_d.was_member = hit_q;
      out_d.table_full = do_drop;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q       <= STEP_INIT;
      idx_q       <= '0;
      cmp_v_q     <= 1'b0;
      hit_q       <= 1'b0;
      empty_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      upc_q       <= upc_d;
      idx_q       <= idx_d;
      cmp_v_q     <= cmp_v_d;
      hit_q       <= hit_d;
      empty_q     <= empty_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers, no reset needed.
  always_ff @(posedge clk_i) begin
    req_q       <= req_d;
    pos_q       <= pos_d;
    cmp_idx_q   <= cmp_idx_d;
    hit_idx_q   <= hit_idx_d;
    empty_idx_q <= empty_idx_d;
    out_q       <= out_d;
  end

  assign in_stall_o  = !ctl.accept;
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

endmodule

// ----- src/iss_checker.sv -----
// Port-level checker for the identifier selection set, with its bind.
module iss_port_checker
  import iss_pkg::*;
(
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_valid_i,
  input logic     in_stall_o,
  input iss_req_t in_req_i,
  input logic     out_valid_o,
  input logic     out_stall_i,
  input iss_rsp_t out_rsp_o
);

  // One request at a time: an accepted request closes the input.
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input open right after an accepted request");

  // A dropped insert means the identifier was absent.
  a_full_not_member: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_rsp_o.was_member && out_rsp_o.table_full))
    else $error("result flags both member and table full");

  // Clearing pass: input closed on the first cycle out of reset.
  a_init_closed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(rst_ni) |-> in_stall_o)
    else $error("request taken during clearing pass");

  // Stalled result holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_rsp_o))
    else $error("stalled result changed");

endmodule

bind id_selection_set_core iss_port_checker u_iss_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_req_i    (in_req_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_rsp_o   (out_rsp_o)
);
